FILE: src/xrr_pkg.sv
// Package for the round-robin crossbar router: widths, codes, FIFO entry layout
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package xrr_pkg;

  localparam int NUM_PORTS  = 4;
  localparam int PORT_W     = 2;
  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 16;
  localparam int DATA_W     = 64;
  localparam int ROUTED_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_TICK = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STS_DONE       = 2'd0,
    STS_PUSH_FULL  = 2'd1,
    STS_POP_EMPTY  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE_EN  = 3'd0,
    CFG_FORCE_CH  = 3'd1,
    CFG_ILV_EN    = 3'd2,
    CFG_ILV_SHIFT = 3'd3,
    CFG_CH_SHIFT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP,
    S_TICK_RD,
    S_TICK_WR,
    S_DONE
  } state_t;

  // one queued transaction
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              wr_flag;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic capture;   // latch the accepted item
    logic push;      // push into the input FIFO of the item's port
    logic pop;       // pop from the channel FIFO of the item's port
    logic tick_rd;   // read the head of the visited input
    logic tick_wr;   // forward that head if its channel has room
    logic step_adv;  // move on to the next input of the tick
    logic load_out;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic in_empty;  // visited input FIFO holds nothing
    logic step_last; // visiting the last input of the tick
    logic out_free;  // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

FILE: src/xrr_ifs.sv
// Valid/ready channel interfaces of the crossbar router: request, result and
// configuration write. Depends on xrr_pkg.
`default_nettype none

interface xrr_req_if import xrr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [PORT_W-1:0]   port;
  logic [ADDR_W-1:0]   address;
  logic                wr_flag;
  logic [TAG_W-1:0]    tag;
  logic [DATA_W-1:0]   payload;

  modport source (output valid, action, port, address, wr_flag, tag, payload,
                  input ready);
  modport sink   (input valid, action, port, address, wr_flag, tag, payload,
                  output ready);
endinterface

interface xrr_rsp_if import xrr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_W-1:0]    out_address;
  logic                 out_wr_flag;
  logic [TAG_W-1:0]     out_tag;
  logic [DATA_W-1:0]    out_payload;
  logic [NUM_PORTS-1:0] moved_mask;
  logic [ROUTED_W-1:0]  routed_count;

  modport source (output valid, status, out_address, out_wr_flag, out_tag,
                  out_payload, moved_mask, routed_count, input ready);
  modport sink   (input valid, status, out_address, out_wr_flag, out_tag,
                  out_payload, moved_mask, routed_count, output ready);
endinterface

interface xrr_cfg_if import xrr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/xrr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module xrr_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: src/xrr_ctrl.sv
// Controller of the crossbar router: sequences push, pop and tick steps.
// Depends on xrr_pkg.
`default_nettype none

module xrr_ctrl import xrr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (in_action)
            ACT_PUSH: state_nxt = S_PUSH;
            ACT_POP:  state_nxt = S_POP;
            ACT_TICK: state_nxt = S_TICK_RD;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_DONE;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_DONE;
      end
      S_TICK_RD: begin
        if (sts.in_empty) begin
          cmd.step_adv = 1'b1;
          state_nxt    = sts.step_last ? S_DONE : S_TICK_RD;
        end else begin
          cmd.tick_rd = 1'b1;
          state_nxt   = S_TICK_WR;
        end
      end
      S_TICK_WR: begin
        cmd.tick_wr  = 1'b1;
        cmd.step_adv = 1'b1;
        state_nxt    = sts.step_last ? S_DONE : S_TICK_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/xrr_datapath.sv
// Datapath of the crossbar router: FIFO pointers and counts, routing and
// address rewrite, config registers and result register.
// Depends on xrr_pkg and xrr_ram.
`default_nettype none

module xrr_datapath import xrr_pkg::*; #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [1:0]            in_action,
  input  logic [PORT_W-1:0]     in_port,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  in_wr_flag,
  input  logic [TAG_W-1:0]      in_tag,
  input  logic [DATA_W-1:0]     in_payload,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [ADDR_W-1:0]     out_address,
  output logic                  out_wr_flag,
  output logic [TAG_W-1:0]      out_tag,
  output logic [DATA_W-1:0]     out_payload,
  output logic [NUM_PORTS-1:0]  out_moved_mask,
  output logic [ROUTED_W-1:0]   out_routed_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int SLOTS  = NUM_PORTS * FIFO_DEPTH;
  localparam int RAM_AW = $clog2(SLOTS);
  localparam int ENT_W  = $bits(entry_t);

  // (h + c) mod depth, valid while c < depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] h,
                                                input logic [CNT_W-1:0] c);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(c);
    if (s >= (CNT_W+1)'(FIFO_DEPTH)) begin
      s = s - (CNT_W+1)'(FIFO_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [RAM_AW-1:0] slot(input logic [PORT_W-1:0] p,
                                             input logic [PTR_W-1:0]  ptr);
    return RAM_AW'(p) * RAM_AW'(FIFO_DEPTH) + RAM_AW'(ptr);
  endfunction

  // two address bits from sh upward; above bit 63 reads as zero
  function automatic logic [1:0] field2(input logic [ADDR_W-1:0] a,
                                        input logic [5:0] sh);
    logic [ADDR_W:0] ext;
    logic [6:0]      lo;
    ext = {1'b0, a};
    lo  = {1'b0, sh};
    return {ext[lo + 7'd1], ext[lo]};
  endfunction

  // item
  logic [1:0]          act_r;
  logic [PORT_W-1:0]   port_r;
  entry_t              item_r;

  // FIFO bookkeeping
  logic [CNT_W-1:0]    in_cnt_r   [NUM_PORTS];
  logic [CNT_W-1:0]    in_cnt_nxt [NUM_PORTS];
  logic [PTR_W-1:0]    in_head_r  [NUM_PORTS];
  logic [PTR_W-1:0]    in_head_nxt[NUM_PORTS];
  logic [CNT_W-1:0]    out_cnt_r   [NUM_PORTS];
  logic [CNT_W-1:0]    out_cnt_nxt [NUM_PORTS];
  logic [PTR_W-1:0]    out_head_r  [NUM_PORTS];
  logic [PTR_W-1:0]    out_head_nxt[NUM_PORTS];
  logic [ROUTED_W-1:0] routed_r  [NUM_PORTS];
  logic [ROUTED_W-1:0] routed_nxt[NUM_PORTS];

  logic [PORT_W-1:0]    start_r, start_nxt;
  logic [PORT_W-1:0]    step_r, step_nxt;
  logic [NUM_PORTS-1:0] mask_r, mask_nxt;
  status_t              status_r, status_nxt;
  logic                 pop_ok_r, pop_ok_nxt;

  // config
  logic       force_en_r;
  logic [1:0] force_ch_r;
  logic       ilv_en_r;
  logic [5:0] ilv_shift_r;
  logic [5:0] chan_sh_r;

  // result register
  logic                 out_valid_r;
  status_t              res_status_r;
  entry_t               res_entry_r;
  logic [NUM_PORTS-1:0] res_mask_r;
  logic [ROUTED_W-1:0]  res_routed_r;

  logic [PORT_W-1:0] ip, in_sel, out_sel, ch;
  logic [CNT_W-1:0]  in_cnt_sel, out_cnt_sel;
  logic [PTR_W-1:0]  in_head_sel, out_head_sel;
  logic              in_full, out_full, out_empty;
  logic              push_ok, pop_ok, move;
  logic [ADDR_W-1:0] chan_mask, fwd_addr;
  entry_t            head_e, fwd_e, pop_e;

  logic [ENT_W-1:0]  in_rd_data, out_rd_data;
  logic [RAM_AW-1:0] in_wr_addr, in_rd_addr, out_wr_addr, out_rd_addr;

  assign ip          = start_r + step_r;
  assign in_sel      = (act_r == ACT_TICK) ? ip : port_r;
  assign in_cnt_sel  = in_cnt_r[in_sel];
  assign in_head_sel = in_head_r[in_sel];
  assign in_full     = (in_cnt_sel == CNT_W'(FIFO_DEPTH));

  // routing of the input head read last cycle
  assign head_e = entry_t'(in_rd_data);
  always_comb begin
    if (force_en_r) begin
      ch = force_ch_r;
    end else if (ilv_en_r) begin
      ch = field2(head_e.address, ilv_shift_r);
    end else begin
      ch = field2(head_e.address, chan_sh_r);
    end
  end

  assign chan_mask = ADDR_W'(2'b11) << chan_sh_r;
  assign fwd_addr  = (force_en_r || ilv_en_r)
                   ? ((head_e.address & ~chan_mask) | (ADDR_W'(ch) << chan_sh_r))
                   : head_e.address;
  always_comb begin
    fwd_e         = head_e;
    fwd_e.address = fwd_addr;
  end

  assign out_sel      = (act_r == ACT_TICK) ? ch : port_r;
  assign out_cnt_sel  = out_cnt_r[out_sel];
  assign out_head_sel = out_head_r[out_sel];
  assign out_full     = (out_cnt_sel == CNT_W'(FIFO_DEPTH));
  assign out_empty    = (out_cnt_sel == '0);

  assign push_ok = cmd.push && !in_full;
  assign pop_ok  = cmd.pop && !out_empty;
  assign move    = cmd.tick_wr && !out_full;

  assign in_wr_addr  = slot(port_r, wrap_add(in_head_sel, in_cnt_sel));
  assign in_rd_addr  = slot(ip, in_head_sel);
  assign out_wr_addr = slot(ch, wrap_add(out_head_sel, out_cnt_sel));
  assign out_rd_addr = slot(port_r, out_head_sel);

  xrr_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_in_ram (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (in_wr_addr),
    .wr_data (item_r),
    .rd_en   (cmd.tick_rd),
    .rd_addr (in_rd_addr),
    .rd_data (in_rd_data)
  );

  xrr_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_out_ram (
    .clk     (clk),
    .wr_en   (move),
    .wr_addr (out_wr_addr),
    .wr_data (fwd_e),
    .rd_en   (pop_ok),
    .rd_addr (out_rd_addr),
    .rd_data (out_rd_data)
  );

  always_comb begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      in_cnt_nxt[i]   = in_cnt_r[i];
      in_head_nxt[i]  = in_head_r[i];
      out_cnt_nxt[i]  = out_cnt_r[i];
      out_head_nxt[i] = out_head_r[i];
      routed_nxt[i]   = routed_r[i];
      if (push_ok && port_r == PORT_W'(i)) begin
        in_cnt_nxt[i] = in_cnt_r[i] + CNT_W'(1);
      end
      if (move && ip == PORT_W'(i)) begin
        in_cnt_nxt[i]  = in_cnt_r[i] - CNT_W'(1);
        in_head_nxt[i] = wrap_add(in_head_r[i], CNT_W'(1));
      end
      if (move && ch == PORT_W'(i)) begin
        out_cnt_nxt[i] = out_cnt_r[i] + CNT_W'(1);
        routed_nxt[i]  = routed_r[i] + ROUTED_W'(1);
      end
      if (pop_ok && port_r == PORT_W'(i)) begin
        out_cnt_nxt[i]  = out_cnt_r[i] - CNT_W'(1);
        out_head_nxt[i] = wrap_add(out_head_r[i], CNT_W'(1));
      end
    end
  end

  always_comb begin
    status_nxt = status_r;
    pop_ok_nxt = pop_ok_r;
    mask_nxt   = mask_r;
    step_nxt   = step_r;
    start_nxt  = start_r;
    if (cmd.capture) begin
      status_nxt = STS_DONE;
      pop_ok_nxt = 1'b0;
      mask_nxt   = '0;
    end
    if (cmd.push && in_full) begin
      status_nxt = STS_PUSH_FULL;
    end
    if (cmd.pop) begin
      pop_ok_nxt = !out_empty;
      if (out_empty) begin
        status_nxt = STS_POP_EMPTY;
      end
    end
    if (move) begin
      mask_nxt[ip] = 1'b1;
    end
    if (cmd.step_adv) begin
      step_nxt = step_r + PORT_W'(1);
      if (sts.step_last) begin
        start_nxt = start_r + PORT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        in_cnt_r[i]   <= '0;
        in_head_r[i]  <= '0;
        out_cnt_r[i]  <= '0;
        out_head_r[i] <= '0;
        routed_r[i]   <= '0;
      end
      act_r       <= ACT_PUSH;
      port_r      <= '0;
      start_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      force_en_r  <= 1'b0;
      force_ch_r  <= '0;
      ilv_en_r    <= 1'b0;
      ilv_shift_r <= '0;
      chan_sh_r   <= '0;
    end else begin
      in_cnt_r    <= in_cnt_nxt;
      in_head_r   <= in_head_nxt;
      out_cnt_r   <= out_cnt_nxt;
      out_head_r  <= out_head_nxt;
      routed_r    <= routed_nxt;
      start_r     <= start_nxt;
      step_r      <= step_nxt;
      if (cmd.capture) begin
        act_r  <= in_action;
        port_r <= in_port;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FORCE_EN:  force_en_r  <= cfg_data[0];
          CFG_FORCE_CH:  force_ch_r  <= cfg_data[1:0];
          CFG_ILV_EN:    ilv_en_r    <= cfg_data[0];
          CFG_ILV_SHIFT: ilv_shift_r <= cfg_data[5:0];
          CFG_CH_SHIFT:  chan_sh_r   <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  // item and result payload, no reset
  assign pop_e = entry_t'(out_rd_data);
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pop_ok_r <= pop_ok_nxt;
    mask_r   <= mask_nxt;
    if (cmd.capture) begin
      item_r.address  <= in_address;
      item_r.wr_flag  <= in_wr_flag;
      item_r.tag      <= in_tag;
      item_r.payload  <= in_payload;
    end
    if (cmd.load_out) begin
      res_status_r <= status_r;
      res_entry_r  <= pop_ok_r ? pop_e : '0;
      res_mask_r   <= mask_r;
      res_routed_r <= routed_r[port_r];
    end
  end

  assign sts.in_empty  = (in_cnt_sel == '0);
  assign sts.step_last = (step_r == PORT_W'(NUM_PORTS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_status       = res_status_r;
  assign out_address      = res_entry_r.address;
  assign out_wr_flag      = res_entry_r.wr_flag;
  assign out_tag          = res_entry_r.tag;
  assign out_payload      = res_entry_r.payload;
  assign out_moved_mask   = res_mask_r;
  assign out_routed_count = res_routed_r;

`ifndef SYNTHESIS
  // channel count only meaningful once the tick head has been read
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_cnt_sel <= CNT_W'(FIFO_DEPTH) &&
    ((act_r == ACT_TICK && !cmd.tick_wr) || out_cnt_sel <= CNT_W'(FIFO_DEPTH)))
    else $error("FIFO count beyond depth");

  a_start_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_adv && sts.step_last |=> start_r == $past(start_r) + PORT_W'(1))
    else $error("start port did not advance at end of tick");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_valid_r || out_ready)
    else $error("result register overwritten while held");

  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok_r |-> status_r == STS_DONE)
    else $error("successful pop flagged with an error status");
`endif

endmodule

`default_nettype wire

FILE: src/crossbar_round_robin_router.sv
// Top level of the 4x4 round-robin crossbar router.
// Depends on xrr_pkg, xrr_ifs, xrr_ctrl, xrr_datapath (and xrr_ram below it).
`default_nettype none

// Four requester input FIFOs and four channel output FIFOs, FIFO_DEPTH items
// each, held in two RAMs of 4*FIFO_DEPTH entries (one per direction). Each
// request item is a push (queue a transaction on input 'port'), a pop (take
// the head of channel 'port') or a tick (visit all four inputs once, starting
// at a rotating start port, forwarding each non-empty head to its channel
// unless that channel is full). Exactly one result item comes back per
// request. Items are handled one at a time: a push or pop is accepted, done in
// its own state and its result loaded; a tick steps past each empty input in
// one state and reads a non-empty head from the input RAM's registered port
// before forwarding it. One result may wait in the output register while the
// next request is accepted. Configuration writes are taken at any time (cfg
// ready is tied high) and must only be made while the router is idle. There
// is no clearing pass after reset.

module crossbar_round_robin_router import xrr_pkg::*; #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  xrr_req_if.sink   in_ch,
  xrr_rsp_if.source out_ch,
  xrr_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: one item in flight, tick walks the inputs step by step
  xrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // FIFO storage and bookkeeping, routing, config and result register
  xrr_datapath #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_ch.action),
    .in_port          (in_ch.port),
    .in_address       (in_ch.address),
    .in_wr_flag       (in_ch.wr_flag),
    .in_tag           (in_ch.tag),
    .in_payload       (in_ch.payload),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_address      (out_ch.out_address),
    .out_wr_flag      (out_ch.out_wr_flag),
    .out_tag          (out_ch.out_tag),
    .out_payload      (out_ch.out_payload),
    .out_moved_mask   (out_ch.moved_mask),
    .out_routed_count (out_ch.routed_count),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data)
  );

endmodule

`default_nettype wire
